// ===== rtl/psbc_pkg.sv =====
package psbc_pkg;

	// Plane slots and register map
	localparam int MAX_PLANES     = 6;
	localparam int NUM_PLANE_REGS = 6;
	localparam int ADDR_W         = 6;
	localparam int DATA_W         = 64;
	localparam int COORD_W        = 16;
	localparam int PROD_W         = 2 * COORD_W;
	localparam int DIST_W         = 35;
	localparam int FRAC_W         = 14;

	localparam logic [2:0] REG_COUNT = 3'd6;

	// Verdict codes
	localparam logic [1:0] VERDICT_IN  = 2'd0;
	localparam logic [1:0] VERDICT_OUT = 2'd1;
	localparam logic [1:0] VERDICT_MID = 2'd2;

	// Item as it travels down the chain of plane cells
	typedef struct packed {
		logic signed [COORD_W-1:0] lo_x;
		logic signed [COORD_W-1:0] lo_y;
		logic signed [COORD_W-1:0] lo_z;
		logic signed [COORD_W-1:0] hi_x;
		logic signed [COORD_W-1:0] hi_y;
		logic signed [COORD_W-1:0] hi_z;
		logic                      bad;
		logic                      all_behind;
		logic                      some_behind;
	} tok_t;

	// Occupancy of one cell's two stages
	typedef struct packed {
		logic s1_full;
		logic s2_full;
	} cell_stat_t;

endpackage

// ===== rtl/psbc_if.sv =====
interface psbc_item_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  kind;
	logic signed [psbc_pkg::COORD_W-1:0]   min_x;
	logic signed [psbc_pkg::COORD_W-1:0]   min_y;
	logic signed [psbc_pkg::COORD_W-1:0]   min_z;
	logic signed [psbc_pkg::COORD_W-1:0]   max_x;
	logic signed [psbc_pkg::COORD_W-1:0]   max_y;
	logic signed [psbc_pkg::COORD_W-1:0]   max_z;
	logic                                  box_valid;

	modport source (output valid, kind, min_x, min_y, min_z, max_x, max_y, max_z, box_valid,
		input ready);
	modport sink (input valid, kind, min_x, min_y, min_z, max_x, max_y, max_z, box_valid,
		output ready);
endinterface

interface psbc_verdict_if;
	logic       valid;
	logic       ready;
	logic [1:0] verdict;

	modport source (output valid, verdict, input ready);
	modport sink (input valid, verdict, output ready);
endinterface

// ===== rtl/psbc_cell.sv =====
module psbc_cell (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [psbc_pkg::DATA_W-1:0]    plane,
	input  logic                           active,
	input  logic                           us_valid,
	output logic                           us_ready,
	input  psbc_pkg::tok_t                 us_tok,
	output logic                           ds_valid,
	input  logic                           ds_ready,
	output psbc_pkg::tok_t                 ds_tok,
	output psbc_pkg::cell_stat_t           stat
);

	logic signed [psbc_pkg::COORD_W-1:0] nrm [3];
	logic signed [psbc_pkg::COORD_W-1:0] lo  [3];
	logic signed [psbc_pkg::COORD_W-1:0] hi  [3];
	logic signed [psbc_pkg::COORD_W-1:0] ofs;

	logic signed [psbc_pkg::PROD_W-1:0] plo_s1 [3];
	logic signed [psbc_pkg::PROD_W-1:0] phi_s1 [3];
	psbc_pkg::tok_t                     tok_s1;
	logic                               vld_s1;
	psbc_pkg::tok_t                     tok_s2;
	logic                               vld_s2;

	logic signed [psbc_pkg::PROD_W-1:0] mn [3];
	logic signed [psbc_pkg::PROD_W-1:0] mx [3];
	logic signed [psbc_pkg::DIST_W-1:0] dterm;
	logic signed [psbc_pkg::DIST_W-1:0] dmin;
	logic signed [psbc_pkg::DIST_W-1:0] dmax;
	psbc_pkg::tok_t                     tok_nx;
	logic                               rdy_s1;
	logic                               rdy_s2;

	assign nrm[0] = plane[15:0];
	assign nrm[1] = plane[31:16];
	assign nrm[2] = plane[47:32];
	assign ofs    = plane[63:48];

	assign lo[0] = us_tok.lo_x;
	assign lo[1] = us_tok.lo_y;
	assign lo[2] = us_tok.lo_z;
	assign hi[0] = us_tok.hi_x;
	assign hi[1] = us_tok.hi_y;
	assign hi[2] = us_tok.hi_z;

	// Stage ready: a stage takes new data when empty or when it hands on
	assign rdy_s2   = !vld_s2 || ds_ready;
	assign rdy_s1   = !vld_s1 || rdy_s2;
	assign us_ready = rdy_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			if (rdy_s1) vld_s1 <= us_valid;
			if (rdy_s2) vld_s2 <= vld_s1;
		end
	end

	// Stage 1: per-axis products for both box extremes
	always_ff @(posedge clk) begin
		if (us_valid && rdy_s1) begin
			tok_s1 <= us_tok;
			for (int k = 0; k < 3; k++) begin
				plo_s1[k] <= nrm[k] * lo[k];
				phi_s1[k] <= nrm[k] * hi[k];
			end
		end
	end

	// Stage 2: nearest and farthest corner distance
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			mn[k] = (plo_s1[k] < phi_s1[k]) ? plo_s1[k] : phi_s1[k];
			mx[k] = (plo_s1[k] < phi_s1[k]) ? phi_s1[k] : plo_s1[k];
		end
		dterm = {{(psbc_pkg::DIST_W-psbc_pkg::COORD_W-psbc_pkg::FRAC_W){ofs[15]}}, ofs,
			{psbc_pkg::FRAC_W{1'b0}}};
		dmin = psbc_pkg::DIST_W'(mn[0]) + psbc_pkg::DIST_W'(mn[1])
			+ psbc_pkg::DIST_W'(mn[2]) + dterm;
		dmax = psbc_pkg::DIST_W'(mx[0]) + psbc_pkg::DIST_W'(mx[1])
			+ psbc_pkg::DIST_W'(mx[2]) + dterm;
		tok_nx             = tok_s1;
		tok_nx.all_behind  = tok_s1.all_behind  || (active && dmax[psbc_pkg::DIST_W-1]);
		tok_nx.some_behind = tok_s1.some_behind || (active && dmin[psbc_pkg::DIST_W-1]);
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && rdy_s2) begin
			tok_s2 <= tok_nx;
		end
	end

	assign ds_valid     = vld_s2;
	assign ds_tok       = tok_s2;
	assign stat.s1_full = vld_s1;
	assign stat.s2_full = vld_s2;

endmodule

// ===== rtl/plane_set_box_culling.sv =====
// Plane-set culling. Each item is a point (kind 0, min fields) or an axis-aligned
// box (kind 1) and gets one verdict: 0 inside, 1 outside, 2 intermediate. The
// planes are written over the APB port at byte address 8*i (plane i packs nx, ny,
// nz in Q2.14 and integer offset d, sixteen bits each, nx lowest); plane_count at
// address 48 selects how many planes, lowest first, take part. Write configuration
// only while no item is in flight. The planes sit in a chain of identical cells,
// one per plane slot, each two stages deep: the first forms the axis products for
// the box minimum and maximum, the second picks the nearest and farthest corner
// and marks the box as wholly or partly behind its plane. One item enters per
// cycle while the result side keeps accepting; each result passes through both
// stages of every cell in the chain and then the output register. Every stage
// stalls on its own, so bubbles close up and the input keeps taking items while
// a finished verdict waits at the output, until every stage is full.
module plane_set_box_culling (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [psbc_pkg::ADDR_W-1:0]   paddr,
	input  logic [psbc_pkg::DATA_W-1:0]   pwdata,
	output logic [psbc_pkg::DATA_W-1:0]   prdata,
	output logic                          pready,
	psbc_item_if.sink                     item,
	psbc_verdict_if.source                result
);

	localparam int NP = psbc_pkg::MAX_PLANES;

	logic [psbc_pkg::DATA_W-1:0] plane_q [NP];
	logic [2:0]                  count_q;
	logic [2:0]                  reg_idx;
	logic [2:0]                  n_act;

	logic                 vld_c [NP+1];
	logic                 rdy_c [NP+1];
	psbc_pkg::tok_t       tok_c [NP+1];
	psbc_pkg::cell_stat_t stat_c [NP];

	logic       out_v_q;
	logic [1:0] verdict_q;
	logic       rdy_o;
	logic       chain_full;

	// Configuration registers: write on the access phase
	assign pready  = 1'b1;
	assign reg_idx = paddr[5:3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NP; i++) plane_q[i] <= '0;
			count_q <= '0;
		end else if (psel && penable && pwrite && pready) begin
			for (int i = 0; i < NP; i++) begin
				if (reg_idx == 3'(i) && i < psbc_pkg::NUM_PLANE_REGS) plane_q[i] <= pwdata;
			end
			if (reg_idx == psbc_pkg::REG_COUNT) count_q <= pwdata[2:0];
		end
	end

	always_comb begin
		prdata = '0;
		for (int i = 0; i < NP; i++) begin
			if (reg_idx == 3'(i)) prdata = plane_q[i];
		end
		if (reg_idx == psbc_pkg::REG_COUNT) prdata = {{(psbc_pkg::DATA_W-3){1'b0}}, count_q};
	end

	// Clamp the active plane count to the slots that exist
	assign n_act = ({1'b0, count_q} > 4'(NP)) ? 3'(NP) : count_q;

	// Chain entry: a point becomes a box with no extent; flag an invalid box
	assign vld_c[0]         = item.valid;
	assign item.ready       = rdy_c[0];
	assign tok_c[0].lo_x    = item.min_x;
	assign tok_c[0].lo_y    = item.min_y;
	assign tok_c[0].lo_z    = item.min_z;
	assign tok_c[0].hi_x    = item.kind ? item.max_x : item.min_x;
	assign tok_c[0].hi_y    = item.kind ? item.max_y : item.min_y;
	assign tok_c[0].hi_z    = item.kind ? item.max_z : item.min_z;
	assign tok_c[0].bad     = item.kind && !item.box_valid;
	assign tok_c[0].all_behind  = 1'b0;
	assign tok_c[0].some_behind = 1'b0;

	for (genvar g = 0; g < NP; g++) begin : g_cell
		psbc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.plane    (plane_q[g]),
			.active   (4'(g) < {1'b0, n_act}),
			.us_valid (vld_c[g]),
			.us_ready (rdy_c[g]),
			.us_tok   (tok_c[g]),
			.ds_valid (vld_c[g+1]),
			.ds_ready (rdy_c[g+1]),
			.ds_tok   (tok_c[g+1]),
			.stat     (stat_c[g])
		);
	end

	// Output register: decode the flags into a verdict, hold until transferred
	assign rdy_o     = !out_v_q || result.ready;
	assign rdy_c[NP] = rdy_o;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_o) begin
			out_v_q <= vld_c[NP];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_o && vld_c[NP]) begin
			if (tok_c[NP].bad) begin
				verdict_q <= psbc_pkg::VERDICT_MID;
			end else if (tok_c[NP].all_behind) begin
				verdict_q <= psbc_pkg::VERDICT_OUT;
			end else if (tok_c[NP].some_behind) begin
				verdict_q <= psbc_pkg::VERDICT_MID;
			end else begin
				verdict_q <= psbc_pkg::VERDICT_IN;
			end
		end
	end

	assign result.valid   = out_v_q;
	assign result.verdict = verdict_q;

	always_comb begin
		chain_full = out_v_q;
		for (int i = 0; i < NP; i++) begin
			chain_full = chain_full && stat_c[i].s1_full && stat_c[i].s2_full;
		end
	end

	// Input stalls only when every stage holds an item
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!item.ready |-> chain_full)
		else $error("input stalled while the pipeline has a bubble");

	// An empty output register never blocks the input
	a_empty_out_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_v_q |-> item.ready)
		else $error("input not ready with an empty output register");

	// A shown verdict is a defined code
	a_verdict_code: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid |-> (result.verdict == psbc_pkg::VERDICT_IN)
			|| (result.verdict == psbc_pkg::VERDICT_OUT)
			|| (result.verdict == psbc_pkg::VERDICT_MID))
		else $error("undefined verdict code");

endmodule
